@@ src/sds_pkg.sv @@
// shared types and constants for the scan disk scheduler
package sds_pkg;

    localparam int TOTAL_W    = 17;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam int DS_W       = 17;
    localparam int HEAD_W     = 16;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [DS_W-1:0]   DS_RESET   = 17'h10000;
    localparam logic [HEAD_W-1:0] HEAD_RESET = 16'h0000;
    localparam logic              UP_RESET   = 1'b1;

    localparam logic [1:0] REG_DISK_SIZE  = 2'd0;
    localparam logic [1:0] REG_START_HEAD = 2'd1;
    localparam logic [1:0] REG_SWEEP_UP   = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic insert;
        logic start;
        logic clear;
        logic ptr_inc;
        logic ptr_dec;
        logic ptr_load_split;
        logic split_save;
        logic emit;
        logic emit_end;
        logic emit_desc;
        logic emit_last;
    } sds_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ptr_at_n;
        logic ptr_zero;
        logic ptr_one;
        logic ptr_last;
        logic above_head;
        logic split_zero;
        logic split_full;
        logic dir_up;
        logic out_free;
    } sds_status_t;

endpackage

@@ src/sds_regs.sv @@
// apb configuration registers of the scan disk scheduler
module sds_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sds_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sds_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sds_pkg::APB_DATA_W-1:0]  prdata,
    output logic [sds_pkg::DS_W-1:0]        disk_size,
    output logic [sds_pkg::HEAD_W-1:0]      start_head,
    output logic                            sweep_up
);

    logic [sds_pkg::DS_W-1:0]   disk_size_reg;
    logic [sds_pkg::HEAD_W-1:0] start_head_reg;
    logic                       sweep_up_reg;
    logic [1:0]                 reg_idx;
    logic                       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_size_reg  <= sds_pkg::DS_RESET;
            start_head_reg <= sds_pkg::HEAD_RESET;
            sweep_up_reg   <= sds_pkg::UP_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                sds_pkg::REG_DISK_SIZE: begin
                    disk_size_reg <= pwdata[sds_pkg::DS_W-1:0];
                end
                sds_pkg::REG_START_HEAD: begin
                    start_head_reg <= pwdata[sds_pkg::HEAD_W-1:0];
                end
                sds_pkg::REG_SWEEP_UP: begin
                    sweep_up_reg <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            sds_pkg::REG_DISK_SIZE: begin
                prdata = sds_pkg::APB_DATA_W'(disk_size_reg);
            end
            sds_pkg::REG_START_HEAD: begin
                prdata = sds_pkg::APB_DATA_W'(start_head_reg);
            end
            sds_pkg::REG_SWEEP_UP: begin
                prdata = sds_pkg::APB_DATA_W'(sweep_up_reg);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign disk_size  = disk_size_reg;
    assign start_head = start_head_reg;
    assign sweep_up   = sweep_up_reg;

endmodule

@@ src/sds_ctrl.sv @@
// sequencer for loading, split search and sweep replay
module sds_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_batch_end,
    output logic                s_ready,
    input  sds_pkg::sds_status_t sts,
    output sds_pkg::sds_cmd_t   cmd
);

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_SPLIT = 5'b00010,
        ST_SIDE1 = 5'b00100,
        ST_TURN  = 5'b01000,
        ST_SIDE2 = 5'b10000
    } sds_state_t;

    sds_state_t state_reg;
    sds_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.insert = 1'b1;
                    if (s_batch_end) begin
                        cmd.start  = 1'b1;
                        state_next = ST_SPLIT;
                    end
                end
            end
            ST_SPLIT: begin
                // first stored request above the head, or the end of the store, marks the split
                if (sts.ptr_at_n || sts.above_head) begin
                    cmd.split_save = 1'b1;
                    state_next     = ST_SIDE1;
                end else begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_SIDE1: begin
                if (sts.dir_up) begin
                    if (sts.ptr_at_n) begin
                        state_next = ST_TURN;
                    end else if (sts.out_free) begin
                        cmd.emit    = 1'b1;
                        cmd.ptr_inc = 1'b1;
                    end
                end else begin
                    if (sts.ptr_zero) begin
                        state_next = ST_TURN;
                    end else if (sts.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_desc = 1'b1;
                        cmd.ptr_dec   = 1'b1;
                    end
                end
            end
            ST_TURN: begin
                if (sts.out_free) begin
                    cmd.emit           = 1'b1;
                    cmd.emit_end       = 1'b1;
                    cmd.ptr_load_split = 1'b1;
                    // nothing left on the far side ends the sweep here
                    if (sts.dir_up ? sts.split_zero : sts.split_full) begin
                        cmd.emit_last = 1'b1;
                        cmd.clear     = 1'b1;
                        state_next    = ST_LOAD;
                    end else begin
                        state_next = ST_SIDE2;
                    end
                end
            end
            ST_SIDE2: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.dir_up) begin
                        cmd.emit_desc = 1'b1;
                        cmd.ptr_dec   = 1'b1;
                        cmd.emit_last = sts.ptr_one;
                    end else begin
                        cmd.ptr_inc   = 1'b1;
                        cmd.emit_last = sts.ptr_last;
                    end
                    if (cmd.emit_last) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

@@ src/sds_dp.sv @@
// sorted request store, sweep pointer, movement accumulator and output register
module sds_dp #(
    parameter int MAX_REQUESTS = 32,
    parameter int CYL_BITS     = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sds_pkg::sds_cmd_t            cmd,
    output sds_pkg::sds_status_t         sts,
    input  logic [sds_pkg::DS_W-1:0]     disk_size,
    input  logic [sds_pkg::HEAD_W-1:0]   start_head,
    input  logic                         sweep_up,
    input  logic [CYL_BITS-1:0]          s_cylinder,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [CYL_BITS-1:0]          m_position,
    output logic [sds_pkg::TOTAL_W-1:0]  m_movement_total,
    output logic                         m_is_end_stop,
    output logic                         m_overflow,
    output logic                         m_last
);

    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int HW = (CYL_BITS > sds_pkg::HEAD_W) ? CYL_BITS : sds_pkg::HEAD_W;
    localparam int DW = (CYL_BITS + 1 > sds_pkg::DS_W) ? CYL_BITS + 1 : sds_pkg::DS_W;
    localparam int SW = ((HW > sds_pkg::TOTAL_W) ? HW : sds_pkg::TOTAL_W) + 1;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_REQUESTS);

    logic [CYL_BITS-1:0]         sorted_reg [MAX_REQUESTS];
    logic [CYL_BITS-1:0]         sorted_next [MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0]     sorted_we;
    logic [MAX_REQUESTS-1:0]     gt;
    logic [CW-1:0]               count_reg;
    logic                        dropped_reg;
    logic [CW-1:0]               ptr_reg;
    logic [CW-1:0]               split_reg;
    logic [HW-1:0]               head_reg;
    logic [sds_pkg::TOTAL_W-1:0] total_reg;
    logic                        dir_reg;

    logic                        m_valid_reg;
    logic [CYL_BITS-1:0]         m_position_reg;
    logic [sds_pkg::TOTAL_W-1:0] m_total_reg;
    logic                        m_end_reg;
    logic                        m_ovf_reg;
    logic                        m_last_reg;

    logic [DW-1:0]               ds;
    logic [DW-1:0]               ds_m1;
    logic [CYL_BITS-1:0]         top;
    logic [CYL_BITS-1:0]         ins_val;
    logic                        full;
    logic [CW-1:0]               rd_ptr;
    logic [IW-1:0]               rd_idx;
    logic [CYL_BITS-1:0]         rd_val;
    logic [CYL_BITS-1:0]         pos;
    logic [HW-1:0]               pos_ext;
    logic [HW-1:0]               seek_len;
    logic [SW-1:0]               sum;
    logic [sds_pkg::TOTAL_W-1:0] total_next;

    // upper sweep end from the disk size, zero and oversize folded in
    assign ds    = DW'(disk_size);
    assign ds_m1 = ds - DW'(1);
    always_comb begin
        if (ds == '0) begin
            top = '0;
        end else if (ds > (DW'(1) << CYL_BITS)) begin
            top = '1;
        end else begin
            top = ds_m1[CYL_BITS-1:0];
        end
    end

    assign ins_val = (s_cylinder > top) ? top : s_cylinder;
    assign full    = (count_reg == CNT_MAX);

    // insertion keeps the store in ascending order, one request per beat
    always_comb begin
        for (int i = 0; i < MAX_REQUESTS; i++) begin
            gt[i] = (CW'(i) < count_reg) && (sorted_reg[i] > ins_val);
        end
        for (int i = 0; i < MAX_REQUESTS; i++) begin
            sorted_we[i]   = cmd.insert && !full && (gt[i] || (CW'(i) == count_reg));
            sorted_next[i] = ins_val;
            if (i > 0) begin
                if (gt[i-1]) begin
                    sorted_next[i] = sorted_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_REQUESTS; i++) begin
            if (sorted_we[i]) begin
                sorted_reg[i] <= sorted_next[i];
            end
        end
    end

    assign rd_ptr = cmd.emit_desc ? (ptr_reg - CW'(1)) : ptr_reg;
    assign rd_idx = rd_ptr[IW-1:0];
    assign rd_val = sorted_reg[rd_idx];

    always_comb begin
        if (cmd.emit_end) begin
            pos = dir_reg ? top : '0;
        end else begin
            pos = rd_val;
        end
    end

    assign pos_ext  = HW'(pos);
    assign seek_len = (pos_ext > head_reg) ? (pos_ext - head_reg) : (head_reg - pos_ext);
    assign sum      = SW'(total_reg) + SW'(seek_len);
    assign total_next = (sum > SW'(sds_pkg::TOTAL_MAX)) ? sds_pkg::TOTAL_MAX
                                                         : sum[sds_pkg::TOTAL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            ptr_reg     <= '0;
            split_reg   <= '0;
            dir_reg     <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end else if (cmd.insert) begin
                if (full) begin
                    dropped_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (cmd.start) begin
                ptr_reg <= '0;
                dir_reg <= sweep_up;
            end else if (cmd.ptr_load_split) begin
                ptr_reg <= split_reg;
            end else if (cmd.ptr_inc) begin
                ptr_reg <= ptr_reg + CW'(1);
            end else if (cmd.ptr_dec) begin
                ptr_reg <= ptr_reg - CW'(1);
            end
            if (cmd.split_save) begin
                split_reg <= ptr_reg;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            head_reg  <= HW'(start_head);
            total_reg <= '0;
        end else if (cmd.emit) begin
            head_reg  <= pos_ext;
            total_reg <= total_next;
        end
        if (cmd.emit) begin
            m_position_reg <= pos;
            m_total_reg    <= total_next;
            m_end_reg      <= cmd.emit_end;
            m_ovf_reg      <= dropped_reg;
            m_last_reg     <= cmd.emit_last;
        end
    end

    assign sts.ptr_at_n   = (ptr_reg == count_reg);
    assign sts.ptr_zero   = (ptr_reg == '0);
    assign sts.ptr_one    = (ptr_reg == CW'(1));
    assign sts.ptr_last   = (CW'(ptr_reg + CW'(1)) == count_reg);
    assign sts.above_head = (HW'(rd_val) > head_reg);
    assign sts.split_zero = (split_reg == '0);
    assign sts.split_full = (split_reg == count_reg);
    assign sts.dir_up     = dir_reg;
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_position       = m_position_reg;
    assign m_movement_total = m_total_reg;
    assign m_is_end_stop    = m_end_reg;
    assign m_overflow       = m_ovf_reg;
    assign m_last           = m_last_reg;

    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result written over an untaken beat");

    a_drop_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.insert && full && !cmd.clear) |=> dropped_reg)
        else $error("request dropped without flag");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.emit_last) |=> (count_reg == '0 && !dropped_reg))
        else $error("store not emptied after sweep");

    a_total_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && !cmd.start) |=> (total_reg >= $past(total_reg)))
        else $error("movement total went down");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |=> (count_reg <= CNT_MAX))
        else $error("request count past capacity");

endmodule

@@ src/scan_disk_scheduler.sv @@
// a request beat without end of batch is stored and gives no result
// after the closing request the split search walks the sorted store to the first request above the head
// the sweep then gives one position per cycle while m_ready holds, with an end stop between the two sides
// throughput: one request per cycle while loading, bounded by the single insert port
// reset (aresetn low at a clock edge) empties the batch and loads the default registers
module scan_disk_scheduler #(
    parameter int MAX_REQUESTS = 32,
    parameter int CYL_BITS     = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sds_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sds_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sds_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [CYL_BITS-1:0]             s_cylinder,
    input  logic                            s_batch_end,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [CYL_BITS-1:0]             m_position,
    output logic [sds_pkg::TOTAL_W-1:0]     m_movement_total,
    output logic                            m_is_end_stop,
    output logic                            m_overflow,
    output logic                            m_last
);

    sds_pkg::sds_cmd_t         cmd;
    sds_pkg::sds_status_t      sts;
    logic [sds_pkg::DS_W-1:0]   disk_size;
    logic [sds_pkg::HEAD_W-1:0] start_head;
    logic                       sweep_up;

    assign pready = 1'b1;

    sds_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .disk_size  (disk_size),
        .start_head (start_head),
        .sweep_up   (sweep_up)
    );

    sds_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_batch_end (s_batch_end),
        .s_ready     (s_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    sds_dp #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .CYL_BITS     (CYL_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .disk_size        (disk_size),
        .start_head       (start_head),
        .sweep_up         (sweep_up),
        .s_cylinder       (s_cylinder),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_position       (m_position),
        .m_movement_total (m_movement_total),
        .m_is_end_stop    (m_is_end_stop),
        .m_overflow       (m_overflow),
        .m_last           (m_last)
    );

endmodule
